/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("port check failed");

// Boolean condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen on ports");

`endif

/* src/ple_pkg.sv */
// Package: sizes, codes and control types of the positional list engine.
package ple_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // digit converter: divide by ten through a reciprocal
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;
  localparam int unsigned QUOT_W      = 64 - DIV10_SHIFT;
  // at most ten digits, each at most nine, weights up to 2^9
  localparam int unsigned DC_ACC_W    = 14;
  localparam int unsigned DC_SHIFT_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_GET       = 4'd0,
    OP_SET       = 4'd1,
    OP_INS_FRONT = 4'd2,
    OP_INS_BACK  = 4'd3,
    OP_INS_AT    = 4'd4,
    OP_RM_FRONT  = 4'd5,
    OP_RM_BACK   = 4'd6,
    OP_RM_AT     = 4'd7,
    OP_SEARCH    = 4'd8,
    OP_CLEAR     = 4'd9,
    OP_SUM       = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_WRITE,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_ROTATE
  } cell_act_e;

  typedef struct packed {
    cell_act_e        act;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CONV,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    DC_IDLE,
    DC_MUL,
    DC_ACC
  } dconv_state_e;

endpackage

/* src/positional_list_engine.sv */
// Top level: bounded positional key list built as a ring of shifting cells.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | operation, position, key_value
//  out     | output    | out_valid_o / out_ready_i| status, item_key, sum_total, entry_count
//
// Get, set, inserts, removes, clear, unused codes and searches of an empty list
// complete in the cycle of acceptance; the cell row opens or closes the gap at that edge.
// Other searches rotate the ring once past the head cell; a sum rotates it once
// too and passes each stored key through the digit converter. One word is in
// work at a time. Reset empties the list; cell contents are not cleared. A stalled
// result holds the output register and blocks the next word until it is taken.
module positional_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ple_pkg::OP_W-1:0]          operation_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  input  logic signed [ple_pkg::KEY_W-1:0]  key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [ple_pkg::KEY_W-1:0]  item_key_o,
  output logic signed [ple_pkg::KEY_W-1:0]  sum_total_o,
  output logic [ple_pkg::CNT_W-1:0]         entry_count_o
);
  import ple_pkg::*;

  // cell row
  logic [KEY_W-1:0] cell_val [CAPACITY];
  cell_ctl_t        cell_ctl;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int unsigned LEFT  = (g == 0) ? CAPACITY - 1 : g - 1;
    localparam int unsigned RIGHT = (g == CAPACITY - 1) ? 0 : g + 1;
    ple_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctl_i      (cell_ctl),
      .left_i     (cell_val[LEFT]),
      .right_i    (cell_val[RIGHT]),
      .val_o      (cell_val[g])
    );
  end

  // control and output registers
  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [KEY_W-1:0] item_q, item_d;
  logic [KEY_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;

  // scan working registers
  logic             is_sum_q, is_sum_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             found_q, found_d;
  logic [KEY_W-1:0] sitem_q, sitem_d;
  logic [KEY_W-1:0] total_q, total_d;
  logic [IDX_W-1:0] rot_q, rot_d;

  // digit converter
  logic             conv_start;
  logic             conv_done;
  logic [KEY_W-1:0] conv_val;

  ple_dconv u_dconv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .value_i  (cell_val[0]),
    .done_o   (conv_done),
    .result_o (conv_val)
  );

  // position checks
  op_e              op;
  logic             pos_ok;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [KEY_W-1:0] rd_val;
  logic             rot_in_fill;
  logic             rot_last;

  assign op          = op_e'(operation_i);
  assign pos_ok      = (position_i != '0) && (CMP_W'(position_i) <= CMP_W'(fill_q));
  assign full        = (fill_q == CNT_W'(CAPACITY));
  assign empty       = (fill_q == '0);
  assign pos_idx     = IDX_W'(position_i - 1'b1);
  assign rot_in_fill = (CNT_W'(rot_q) < fill_q);
  assign rot_last    = (rot_q == IDX_W'(CAPACITY - 1));

  // single read port for get and removes
  always_comb begin
    case (op)
      OP_RM_FRONT: rd_idx = '0;
      OP_RM_BACK:  rd_idx = IDX_W'(fill_q - 1'b1);
      default:     rd_idx = pos_idx;
    endcase
  end

  assign rd_val = cell_val[rd_idx];

  // decode of the operations that complete on acceptance, and of scan requests
  status_e          dec_status;
  logic [KEY_W-1:0] dec_item;
  logic [CNT_W-1:0] dec_fill;
  cell_act_e        dec_act;
  logic [IDX_W-1:0] dec_idx;
  logic             dec_scan;

  always_comb begin
    dec_status = ST_OK;
    dec_item   = '0;
    dec_fill   = fill_q;
    dec_act    = ACT_HOLD;
    dec_idx    = pos_idx;
    dec_scan   = 1'b0;
    case (op)
      OP_GET: begin
        if (!pos_ok) dec_status = ST_BADPOS;
        else dec_item = rd_val;
      end
      OP_SET: begin
        if (!pos_ok) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_act  = ACT_WRITE;
          dec_item = key_value_i;
        end
      end
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_act  = ACT_INSERT;
          dec_idx  = (op == OP_INS_FRONT) ? '0 : IDX_W'(fill_q);
          dec_fill = fill_q + 1'b1;
          dec_item = key_value_i;
        end
      end
      OP_INS_AT: begin
        if (!pos_ok) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_act  = ACT_INSERT;
          dec_fill = fill_q + 1'b1;
          dec_item = key_value_i;
        end
      end
      OP_RM_FRONT, OP_RM_BACK, OP_RM_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if ((op == OP_RM_AT) && !pos_ok) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_act  = ACT_REMOVE;
          dec_idx  = rd_idx;
          dec_fill = fill_q - 1'b1;
          dec_item = rd_val;
        end
      end
      OP_SEARCH: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_scan = 1'b1;
      end
      OP_CLEAR: begin
        dec_fill = '0;
      end
      OP_SUM: begin
        dec_scan = 1'b1;
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // sequencer: accept, rotate-scan, convert, deliver
  logic step;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    item_d      = item_q;
    sum_d       = sum_q;
    count_d     = count_q;
    is_sum_d    = is_sum_q;
    key_d       = key_q;
    found_d     = found_q;
    sitem_d     = sitem_q;
    total_d     = total_q;
    rot_d       = rot_q;
    cell_ctl    = '{act: ACT_HOLD, idx: dec_idx, key: key_value_i};
    conv_start  = 1'b0;
    in_ready_o  = 1'b0;
    step        = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (dec_scan) begin
            state_d  = S_SCAN;
            is_sum_d = (op == OP_SUM);
            key_d    = key_value_i;
            found_d  = 1'b0;
            sitem_d  = '1;
            total_d  = '0;
            rot_d    = '0;
          end else begin
            cell_ctl.act = dec_act;
            fill_d       = dec_fill;
            out_valid_d  = 1'b1;
            status_d     = dec_status;
            item_d       = dec_item;
            sum_d        = '0;
            count_d      = dec_fill;
          end
        end
      end
      S_SCAN: begin
        if (is_sum_q && rot_in_fill) begin
          conv_start = 1'b1;
          state_d    = S_CONV;
        end else begin
          step = 1'b1;
          if (!is_sum_q && rot_in_fill && !found_q && (cell_val[0] == key_q)) begin
            found_d = 1'b1;
            sitem_d = cell_val[0];
          end
        end
      end
      S_CONV: begin
        if (conv_done) begin
          total_d = total_q + conv_val;
          step    = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          item_d      = is_sum_q ? '0 : sitem_q;
          sum_d       = is_sum_q ? total_q : '0;
          count_d     = fill_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // advance the ring by one cell towards the head
    if (step) begin
      cell_ctl.act = ACT_ROTATE;
      rot_d        = rot_q + 1'b1;
      state_d      = rot_last ? S_DONE : S_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    item_q   <= item_d;
    sum_q    <= sum_d;
    count_q  <= count_d;
    is_sum_q <= is_sum_d;
    key_q    <= key_d;
    found_q  <= found_d;
    sitem_q  <= sitem_d;
    total_q  <= total_d;
    rot_q    <= rot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign item_key_o    = item_q;
  assign sum_total_o   = sum_q;
  assign entry_count_o = count_q;

endmodule

/* src/ple_cell.sv */
// One list cell: holds one key and shifts with its neighbours on command.
module ple_cell (
  input  logic                         clk_i,
  input  logic [ple_pkg::IDX_W-1:0]    cell_idx_i,
  input  ple_pkg::cell_ctl_t           ctl_i,
  input  logic [ple_pkg::KEY_W-1:0]    left_i,
  input  logic [ple_pkg::KEY_W-1:0]    right_i,
  output logic [ple_pkg::KEY_W-1:0]    val_o
);
  import ple_pkg::*;

  logic [KEY_W-1:0] val_q, val_d;

  // next key: write, open a gap, close a gap or rotate towards the head
  always_comb begin
    val_d = val_q;
    case (ctl_i.act)
      ACT_WRITE: begin
        if (cell_idx_i == ctl_i.idx) val_d = ctl_i.key;
      end
      ACT_INSERT: begin
        if (cell_idx_i == ctl_i.idx) val_d = ctl_i.key;
        else if (cell_idx_i > ctl_i.idx) val_d = left_i;
      end
      ACT_REMOVE: begin
        if (cell_idx_i >= ctl_i.idx) val_d = right_i;
      end
      ACT_ROTATE: begin
        val_d = right_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* src/ple_dconv.sv */
// Digit-serial converter: decimal digits of a key read as binary digits.
module ple_dconv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ple_pkg::KEY_W-1:0]  value_i,
  output logic                       done_o,
  output logic [ple_pkg::KEY_W-1:0]  result_o
);
  import ple_pkg::*;

  dconv_state_e          state_q, state_d;
  logic                  neg_q, neg_d;
  logic [KEY_W-1:0]      mag_q, mag_d;
  logic [63:0]           prod_q, prod_d;
  logic [DC_ACC_W-1:0]   acc_q, acc_d;
  logic [DC_SHIFT_W-1:0] shift_q, shift_d;

  logic [QUOT_W-1:0]     quot;
  logic [KEY_W-1:0]      rem_full;
  logic [DC_ACC_W-1:0]   digit_w;
  logic [KEY_W-1:0]      acc_ext;

  // quotient and remainder of the current magnitude by ten
  assign quot     = prod_q[63:DIV10_SHIFT];
  assign rem_full = mag_q - {quot, 3'b000} - KEY_W'({quot, 1'b0});
  assign digit_w  = DC_ACC_W'(rem_full[3:0]) << shift_q;
  assign acc_ext  = KEY_W'(acc_q);
  assign result_o = neg_q ? (KEY_W'(0) - acc_ext) : acc_ext;

  // per digit: multiply, then subtract and accumulate
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    shift_d = shift_q;
    done_o  = 1'b0;
    case (state_q)
      DC_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[KEY_W-1];
          mag_d   = value_i[KEY_W-1] ? (KEY_W'(0) - value_i) : value_i;
          acc_d   = '0;
          shift_d = '0;
          state_d = DC_MUL;
        end
      end
      DC_MUL: begin
        if (mag_q == '0) begin
          done_o  = 1'b1;
          state_d = DC_IDLE;
        end else begin
          prod_d  = 64'(mag_q) * 64'(DIV10_RECIP);
          state_d = DC_ACC;
        end
      end
      DC_ACC: begin
        acc_d   = acc_q + digit_w;
        shift_d = shift_q + 1'b1;
        mag_d   = KEY_W'(quot);
        state_d = DC_MUL;
      end
      default: begin
        state_d = DC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    shift_q <= shift_d;
  end

endmodule

/* src/ple_checker.sv */
// Port-level checker for the positional list engine, bound to the top level.
`include "assert_macros.svh"

module ple_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [ple_pkg::OP_W-1:0]          operation_i,
  input logic [ple_pkg::POS_W-1:0]         position_i,
  input logic signed [ple_pkg::KEY_W-1:0]  key_value_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        status_o,
  input logic signed [ple_pkg::KEY_W-1:0]  item_key_o,
  input logic signed [ple_pkg::KEY_W-1:0]  sum_total_o,
  input logic [ple_pkg::CNT_W-1:0]         entry_count_o
);
  import ple_pkg::*;

  // stalled result word holds
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(item_key_o) && $stable(status_o) && $stable(entry_count_o))

  // the list never reports more entries than it can hold
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, out_valid_o && (entry_count_o > CNT_W'(CAPACITY)))

  // full is only reported at capacity
  `ASSERT_AT(a_full_count, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL) |-> entry_count_o == CNT_W'(CAPACITY))

  // empty is only reported with no entries
  `ASSERT_AT(a_empty_count, clk_i, rst_ni, out_valid_o && (status_o == ST_EMPTY) |-> entry_count_o == '0)

  // a sum is never paired with an error
  `ASSERT_NEVER(a_sum_err, clk_i, rst_ni, out_valid_o && (sum_total_o != '0) && (status_o != ST_OK))

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the positional list engine: scoreboard, drivers and checks.
`timescale 1ns / 100ps

module tb;
  import ple_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned SETTLE       = 400;

  // codes the block decodes as no operation
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [OP_W-1:0]         operation_i;
  logic [POS_W-1:0]        position_i;
  logic signed [KEY_W-1:0] key_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              status_o;
  logic signed [KEY_W-1:0] item_key_o;
  logic signed [KEY_W-1:0] sum_total_o;
  logic [CNT_W-1:0]        entry_count_o;

  int unsigned cycles;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] item;
    logic [KEY_W-1:0] total;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // Shadow list plus the queue of result words still owed by the block
  class list_scoreboard;
    logic [KEY_W-1:0] keys [CAPACITY];
    int               fill;
    list_result_t     owed [$];
    int unsigned      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // digits of the magnitude taken as binary digits, sign reapplied
    function logic [KEY_W-1:0] digit_value(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mag, acc, weight;
      mag    = key[KEY_W-1] ? -key : key;
      acc    = '0;
      weight = 32'd1;
      while (mag != 0) begin
        acc    = acc + (mag % 10) * weight;
        mag    = mag / 10;
        weight = weight << 1;
      end
      return key[KEY_W-1] ? -acc : acc;
    endfunction

    function void insert_key(int at, logic [KEY_W-1:0] key);
      for (int i = fill; i > at; i--) keys[i] = keys[i-1];
      keys[at] = key;
      fill++;
    endfunction

    // predict the result of one accepted word and update the shadow list
    function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [KEY_W-1:0] key);
      list_result_t r;
      bit           pos_ok;
      int           idx;
      int           at;
      r.status = ST_OK;
      r.item   = '0;
      r.total  = '0;
      pos_ok   = (pos >= 1) && (int'(pos) <= fill);
      idx      = pos_ok ? int'(pos) - 1 : 0;
      case (op)
        OP_GET: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else r.item = keys[idx];
        end
        OP_SET: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else begin
            keys[idx] = key;
            r.item    = key;
          end
        end
        OP_INS_FRONT, OP_INS_BACK: begin
          if (fill >= CAPACITY) r.status = ST_FULL;
          else begin
            insert_key((op == OP_INS_FRONT) ? 0 : fill, key);
            r.item = key;
          end
        end
        OP_INS_AT: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else if (fill >= CAPACITY) r.status = ST_FULL;
          else begin
            insert_key(idx, key);
            r.item = key;
          end
        end
        OP_RM_FRONT, OP_RM_BACK, OP_RM_AT: begin
          // empty list outranks a bad position
          if (fill == 0) r.status = ST_EMPTY;
          else if (op == OP_RM_AT && !pos_ok) r.status = ST_BADPOS;
          else begin
            at     = (op == OP_RM_FRONT) ? 0 : (op == OP_RM_BACK) ? fill - 1 : idx;
            r.item = keys[at];
            for (int i = at; i + 1 < fill; i++) keys[i] = keys[i+1];
            fill--;
          end
        end
        OP_SEARCH: begin
          if (fill == 0) r.status = ST_EMPTY;
          else begin
            r.item = '1;
            for (int i = 0; i < fill; i++) begin
              if (keys[i] == key) begin
                r.item = keys[i];
                break;
              end
            end
          end
        end
        OP_CLEAR: fill = 0;
        OP_SUM: begin
          for (int i = 0; i < fill; i++) r.total = r.total + digit_value(keys[i]);
        end
        default: ;
      endcase
      r.count = fill[CNT_W-1:0];
      owed.push_back(r);
    endfunction

    function void compare_field(string name, logic [KEY_W-1:0] exp_v,
                                logic [KEY_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(logic [1:0] status, logic [KEY_W-1:0] item,
                             logic [KEY_W-1:0] total, logic [CNT_W-1:0] count);
      list_result_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual status %0d item %h",
                 $time, status, item);
        return;
      end
      e = owed.pop_front();
      compare_field("status", 32'(e.status), 32'(status));
      compare_field("item_key", e.item, item);
      compare_field("sum_total", e.total, total);
      compare_field("entry_count", 32'(e.count), 32'(count));
    endfunction
  endclass

  list_scoreboard sb;

  positional_list_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .item_key_o    (item_key_o),
    .sum_total_o   (sum_total_o),
    .entry_count_o (entry_count_o)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one stretch of the cycle count in every four runs without idling
  function automatic bit calm_phase();
    return ((cycles / 1500) % 4) == 1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase()) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mode 0 balanced, 1 leans to inserts, 2 leans to removes
  function automatic logic [OP_W-1:0] pick_op(int unsigned mode);
    int unsigned r, ins_w, rm_w;
    ins_w = (mode == 1) ? 50 : (mode == 2) ? 10 : 28;
    rm_w  = (mode == 2) ? 45 : (mode == 1) ? 8 : 24;
    r     = $urandom_range(0, 99);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_FRONT;
        1:       return OP_INS_BACK;
        default: return OP_INS_AT;
      endcase
    end
    if (r < ins_w + rm_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_RM_FRONT;
        1:       return OP_RM_BACK;
        default: return OP_RM_AT;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 25) return OP_GET;
    if (r < 45) return OP_SET;
    if (r < 70) return OP_SEARCH;
    if (r < 86) return OP_SUM;
    if (r < 93 && mode != 1) return OP_CLEAR;
    return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return POS_W'($urandom_range(1, (sb.fill > 0) ? sb.fill : 1));
    if (r < 85) return POS_W'(sb.fill + 1);
    if (r < 92) return '0;
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 60) return $urandom_range(0, 2000);
    if (r < 75 && sb.fill > 0) return sb.keys[$urandom_range(0, sb.fill - 1)];
    if (r < 85) begin
      case ($urandom_range(0, 6))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0000;
        4:       return 32'h0000_0001;
        5:       return 32'd999_999_999;
        default: return -32'sd999_999_999;
      endcase
    end
    return -$urandom_range(1, 100_000);
  endfunction

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    key_value_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, pos, key);
  endtask

  // Stop offering and wait until every owed result has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    // empty list corners
    send_word(OP_SUM, 8'd0, 32'd0);
    send_word(OP_SEARCH, 8'd1, 32'd5);
    send_word(OP_RM_FRONT, 8'd1, 32'd0);
    send_word(OP_RM_BACK, 8'd1, 32'd0);
    send_word(OP_RM_AT, 8'd0, 32'd0);
    send_word(OP_GET, 8'd1, 32'd0);
    send_word(OP_SET, 8'd1, 32'd7);
    send_word(OP_INS_AT, 8'd1, 32'd7);
    // build a small list with extreme keys
    send_word(OP_INS_FRONT, 8'd0, 32'h7FFF_FFFF);
    send_word(OP_INS_BACK, 8'hFF, 32'h8000_0000);
    send_word(OP_INS_AT, 8'd1, 32'hFFFF_FFFF);
    send_word(OP_INS_BACK, 8'd0, -32'sd1_234_567_890);
    send_word(OP_INS_AT, 8'd4, 32'd0);
    // bad positions, then valid ones, on a filled list
    send_word(OP_GET, 8'hFF, 32'd0);
    send_word(OP_GET, 8'd0, 32'd0);
    send_word(OP_GET, 8'd5, 32'd0);
    send_word(OP_SET, 8'd2, 32'd1_999_999_999);
    // hit on a key of -1, then a miss that also returns -1
    send_word(OP_SEARCH, 8'd0, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 8'd0, 32'd42);
    send_word(OP_SUM, 8'd0, 32'd0);
    send_word(OP_RM_AT, 8'd6, 32'd0);
    send_word(OP_RM_AT, 8'd2, 32'd0);
    send_word(OP_RM_BACK, 8'd0, 32'd0);
    send_word(OP_LAST_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_FIRST_UNUSED, 8'd1, 32'd3);
    send_word(OP_RM_FRONT, 8'd0, 32'd0);
    send_word(OP_CLEAR, 8'd0, 32'd0);
    send_word(OP_SUM, 8'd0, 32'd0);
  endtask

  task automatic run_random();
    int unsigned      done_items, mode, mode_left;
    bit               paused;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    done_items = 0;
    mode       = 0;
    mode_left  = 0;
    paused     = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 150);
      end
      mode_left--;
      op  = pick_op(mode);
      pos = pick_pos();
      key = pick_key();
      send_word(op, pos, key);
      if (op < OP_FIRST_UNUSED) done_items++;
      // one pause halfway until the block has handed back everything
      if (!paused && done_items == RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  // Result side: random back-pressure and one long hold-off
  initial begin : result_sink
    int unsigned stall_left, taken;
    bit          held;
    stall_left  = 0;
    taken       = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_word(status_o, item_key_o, sum_total_o, entry_count_o);
        taken++;
      end
      if (!held && taken >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm_phase() && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = '0;
    position_i  = '0;
    key_value_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    // catch any stray word after the last expected one
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/ple_dconv.sv
src/positional_list_engine.sv
src/ple_checker.sv
tb/tb.sv
